### hdl/assert_macros.svh
// assertion macros used by the checker file
// both expect clk and the active-low synchronous rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define CHK_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rgbhsv_pkg.sv
// types and constants for the rgb to hsv pixel converter
// no dependencies; used by the top level and the checker
package rgbhsv_pkg;

  localparam int CH_W = 8;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] brightness;
  } pix_out_t;

  // sector of the largest channel
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // angles in degrees and the saturation scale
  localparam int DEG_PER_SECTOR = 60;
  localparam int GREEN_OFFSET   = 120;
  localparam int BLUE_OFFSET    = 240;
  localparam int FULL_TURN      = 360;
  localparam int SAT_SCALE      = 255;
  localparam int HUE_MAX        = 179;

  // both quotients fit in one channel
  localparam int QUO_W = CH_W;

  // signed channel difference and signed hue numerator before wrap
  localparam int DIFF_W    = CH_W + 1;
  localparam int HNUM_S_W  = 19;
  // hue numerator after wrap: below 360 * 255
  localparam int HNUM_W    = 17;
  // hue divisor is twice the channel spread
  localparam int HDEN_W    = CH_W + 1;
  // saturation numerator is 255 * spread, divisor is the max channel
  localparam int SNUM_W    = 2 * CH_W;
  localparam int SDEN_W    = CH_W;

endpackage

### hdl/rgbhsv_div.sv
// pipelined restoring divider with a fixed-width quotient
// depends on nothing; each stage resolves BITS_PER_STG quotient bits
module rgbhsv_div #(
  parameter int NUM_W        = 17,
  parameter int DEN_W        = 9,
  parameter int Q_W          = 8,
  parameter int BITS_PER_STG = 2,
  localparam int NSTG        = Q_W / BITS_PER_STG
) (
  input  logic             clk,
  input  logic [NSTG-1:0]  en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  // wide enough that a shifted divisor never wraps
  localparam int CW = NUM_W + Q_W;

  logic [NUM_W-1:0] rem_r [NSTG];
  logic [DEN_W-1:0] den_r [NSTG];
  logic [Q_W-1:0]   quo_r [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic [NUM_W-1:0] rem_nxt;
    logic [Q_W-1:0]   quo_nxt;
    logic [CW-1:0]    part;
    logic [CW-1:0]    shd;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // quotient bits come out msb first and shift in from the bottom
    always_comb begin
      part    = CW'(rem_in);
      quo_nxt = quo_in;
      shd     = '0;
      for (int k = 0; k < BITS_PER_STG; k++) begin
        shd = CW'(den_in) << (Q_W - 1 - s * BITS_PER_STG - k);
        if (part >= shd) begin
          part    = part - shd;
          quo_nxt = {quo_nxt[Q_W-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[Q_W-2:0], 1'b0};
        end
      end
      rem_nxt = part[NUM_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[NSTG-1];

endmodule

### hdl/rgb_to_hsv_pixel.sv
// rgb_to_hsv_pixel: converts one 8-bit rgb pixel per clock into 8-bit hue
// (0..179, two-degree units), saturation and brightness (largest channel).
// The pipeline is made of the two min/max and numerator stages followed by
// the divider stages that work out hue and saturation side by side. A new
// pixel is taken every clock; the pipeline only holds up the input when
// every stage is full and the result is stalled, and bubbles close up under
// a stall. Black and grey pixels give hue and saturation of zero; ties for
// the largest channel go to red, then green.
// DIV_BITS_PER_STAGE may be 1, 2, 4 or 8.
module rgb_to_hsv_pixel #(
  parameter int DIV_BITS_PER_STAGE = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbhsv_pkg::pix_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbhsv_pkg::pix_out_t out_data
);

  import rgbhsv_pkg::*;

  localparam int DSTG = QUO_W / DIV_BITS_PER_STAGE;
  localparam int NST  = 2 + DSTG;

  // stage valid bits and per-stage advance
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) vld_nxt[0] = in_valid;
    for (int i = 1; i < NST; i++) begin
      if (rdy[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NST-1];

  // stage a: max, min, spread, sector and the signed difference
  logic [CH_W-1:0]          mx_a_nxt, mn_a;
  sector_t                  sec_a_nxt;
  logic signed [DIFF_W-1:0] diff_a_nxt;

  logic [CH_W-1:0]          mx_a_r, d_a_r;
  sector_t                  sec_a_r;
  logic signed [DIFF_W-1:0] diff_a_r;

  always_comb begin
    priority if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      sec_a_nxt  = SEC_RED;
      mx_a_nxt   = in_data.red;
      diff_a_nxt = $signed({1'b0, in_data.green}) - $signed({1'b0, in_data.blue});
    end else if (in_data.green >= in_data.blue) begin
      sec_a_nxt  = SEC_GREEN;
      mx_a_nxt   = in_data.green;
      diff_a_nxt = $signed({1'b0, in_data.blue}) - $signed({1'b0, in_data.red});
    end else begin
      sec_a_nxt  = SEC_BLUE;
      mx_a_nxt   = in_data.blue;
      diff_a_nxt = $signed({1'b0, in_data.red}) - $signed({1'b0, in_data.green});
    end
    mn_a = in_data.red;
    if (in_data.green < mn_a) mn_a = in_data.green;
    if (in_data.blue < mn_a) mn_a = in_data.blue;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mx_a_r   <= mx_a_nxt;
      d_a_r    <= mx_a_nxt - mn_a;
      sec_a_r  <= sec_a_nxt;
      diff_a_r <= diff_a_nxt;
    end
  end

  // stage b: division operands
  logic signed [HNUM_S_W-1:0] d_x, off_x, hnum_s;
  logic [HNUM_W-1:0]          hnum_b_nxt;
  logic [HDEN_W-1:0]          hden_b_nxt;
  logic [SNUM_W-1:0]          snum_b_nxt;
  logic [SDEN_W-1:0]          sden_b_nxt;

  logic [HNUM_W-1:0]          hnum_b_r;
  logic [HDEN_W-1:0]          hden_b_r;
  logic [SNUM_W-1:0]          snum_b_r;
  logic [SDEN_W-1:0]          sden_b_r;
  logic [CH_W-1:0]            mx_b_r;

  always_comb begin
    d_x = $signed({{(HNUM_S_W-CH_W){1'b0}}, d_a_r});
    unique case (sec_a_r)
      SEC_RED:   off_x = '0;
      SEC_GREEN: off_x = HNUM_S_W'(d_x * GREEN_OFFSET);
      SEC_BLUE:  off_x = HNUM_S_W'(d_x * BLUE_OFFSET);
      default:   off_x = '0;
    endcase
    hnum_s = HNUM_S_W'(HNUM_S_W'(diff_a_r) * DEG_PER_SECTOR) + off_x;
    // negative angles wrap by a full turn
    if (hnum_s < 0) hnum_s = hnum_s + HNUM_S_W'(d_x * FULL_TURN);
    if (d_a_r == '0) begin
      // grey or black: zero numerators, unit divisors
      hnum_b_nxt = '0;
      hden_b_nxt = HDEN_W'(1);
      snum_b_nxt = '0;
      sden_b_nxt = SDEN_W'(1);
    end else begin
      hnum_b_nxt = hnum_s[HNUM_W-1:0];
      hden_b_nxt = {d_a_r, 1'b0};
      snum_b_nxt = SNUM_W'(SAT_SCALE * d_a_r);
      sden_b_nxt = mx_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hnum_b_r <= hnum_b_nxt;
      hden_b_r <= hden_b_nxt;
      snum_b_r <= snum_b_nxt;
      sden_b_r <= sden_b_nxt;
      mx_b_r   <= mx_a_r;
    end
  end

  // divider stages
  logic [QUO_W-1:0] hue_q, sat_q;

  rgbhsv_div #(
    .NUM_W        (HNUM_W),
    .DEN_W        (HDEN_W),
    .Q_W          (QUO_W),
    .BITS_PER_STG (DIV_BITS_PER_STAGE)
  ) u_hue_div (
    .clk (clk),
    .en  (rdy[NST-1:2]),
    .num (hnum_b_r),
    .den (hden_b_r),
    .quo (hue_q)
  );

  rgbhsv_div #(
    .NUM_W        (SNUM_W),
    .DEN_W        (SDEN_W),
    .Q_W          (QUO_W),
    .BITS_PER_STG (DIV_BITS_PER_STAGE)
  ) u_sat_div (
    .clk (clk),
    .en  (rdy[NST-1:2]),
    .num (snum_b_r),
    .den (sden_b_r),
    .quo (sat_q)
  );

  // brightness rides alongside the divider
  logic [CH_W-1:0] bri_r [DSTG];

  for (genvar s = 0; s < DSTG; s++) begin : g_bri
    always_ff @(posedge clk) begin
      if (rdy[s+2]) begin
        if (s == 0) begin
          bri_r[s] <= mx_b_r;
        end else begin
          bri_r[s] <= bri_r[(s == 0) ? 0 : s-1];
        end
      end
    end
  end

  assign out_data.hue        = hue_q;
  assign out_data.saturation = sat_q;
  assign out_data.brightness = bri_r[DSTG-1];

endmodule

### hdl/rgbhsv_chk.sv
// port-level checks for rgb_to_hsv_pixel, attached by bind
// depends on rgbhsv_pkg and assert_macros.svh
`include "assert_macros.svh"

module rgbhsv_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rgbhsv_pkg::pix_out_t out_data
);

  import rgbhsv_pkg::*;

  // a held result keeps its payload
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // an empty output stage means the whole pipeline can move
  `CHK_HOLDS(a_in_free, !out_valid, !in_stall, "input stalled with empty output")

  `CHK_HOLDS(a_hue_range, out_valid, out_data.hue <= CH_W'(HUE_MAX), "hue above range")

  // zero saturation only for grey pixels, which carry zero hue
  `CHK_HOLDS(a_grey_hue, out_valid && out_data.saturation == '0, out_data.hue == '0, "grey pixel with hue")

  `CHK_HOLDS(a_black, out_valid && out_data.brightness == '0, out_data.saturation == '0, "black pixel with saturation")

endmodule

bind rgb_to_hsv_pixel rgbhsv_chk u_rgbhsv_chk (.*);
